// ===== design/owtr_pkg.sv =====
// ----------------------------------------------------------------------------
// owtr_pkg
// Shared types and constants for the one-wire temperature reader.
// ----------------------------------------------------------------------------
package owtr_pkg;

  localparam int unsigned LONG_W  = 11;
  localparam int unsigned SLOT_W  = 8;
  localparam int unsigned CIDX_W  = 3;
  localparam int unsigned STEP_W  = 4;
  localparam int unsigned BIT_W   = 3;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned NIB_W   = 4;
  localparam int unsigned TENS_W  = 5;

  localparam logic [CIDX_W-1:0] REG_RESET_LOW     = 3'd0;
  localparam logic [CIDX_W-1:0] REG_PRESENCE_WAIT = 3'd1;
  localparam logic [CIDX_W-1:0] REG_RECOVERY      = 3'd2;
  localparam logic [CIDX_W-1:0] REG_SLOT          = 3'd3;
  localparam logic [CIDX_W-1:0] REG_CONVERT_WAIT  = 3'd4;

  localparam logic [LONG_W-1:0] RST_RESET_LOW     = 11'd480;
  localparam logic [LONG_W-1:0] RST_PRESENCE_WAIT = 11'd60;
  localparam logic [LONG_W-1:0] RST_RECOVERY      = 11'd420;
  localparam logic [SLOT_W-1:0] RST_SLOT          = 8'd60;
  localparam logic [LONG_W-1:0] RST_CONVERT_WAIT  = 11'd1000;

  localparam logic [STEP_W-1:0] STEP_RESET_A   = 4'd0;
  localparam logic [STEP_W-1:0] STEP_SKIP_A    = 4'd1;
  localparam logic [STEP_W-1:0] STEP_CONVERT   = 4'd2;
  localparam logic [STEP_W-1:0] STEP_WAIT_A    = 4'd3;
  localparam logic [STEP_W-1:0] STEP_RESET_B   = 4'd4;
  localparam logic [STEP_W-1:0] STEP_SKIP_B    = 4'd5;
  localparam logic [STEP_W-1:0] STEP_READ_CMD  = 4'd6;
  localparam logic [STEP_W-1:0] STEP_WAIT_B    = 4'd7;
  localparam logic [STEP_W-1:0] STEP_READ_LO   = 4'd8;
  localparam logic [STEP_W-1:0] STEP_READ_HI   = 4'd9;
  localparam logic [STEP_W-1:0] STEP_FINISH    = 4'd10;

  localparam logic [BYTE_W-1:0] CMD_SKIP_ROM   = 8'hCC;
  localparam logic [BYTE_W-1:0] CMD_CONVERT    = 8'h44;
  localparam logic [BYTE_W-1:0] CMD_READ_PAD   = 8'hBE;

  localparam logic [BIT_W-1:0]  LAST_BIT       = 3'd7;

  // Reciprocal of ten for 8-bit values: q = (v * 205) >> 11
  localparam logic [BYTE_W-1:0] RECIP_TEN      = 8'd205;
  localparam int unsigned       RECIP_SHIFT    = 11;

  typedef enum logic [4:0] {
    PH_IDLE   = 5'd0,
    PH_RLOW   = 5'd1,
    PH_RWAIT  = 5'd2,
    PH_RREC   = 5'd3,
    PH_WLOW   = 5'd4,
    PH_WBIT   = 5'd5,
    PH_WEND   = 5'd6,
    PH_CWAIT  = 5'd7,
    PH_RDLOW  = 5'd8,
    PH_RDREL  = 5'd9,
    PH_RDWAIT = 5'd10,
    PH_DONE   = 5'd11
  } phase_t;

  typedef struct packed {
    logic [LONG_W-1:0] reset_low_len;
    logic [LONG_W-1:0] presence_wait_len;
    logic [LONG_W-1:0] recovery_len;
    logic [SLOT_W-1:0] slot_len;
    logic [LONG_W-1:0] convert_wait_len;
  } cfg_t;

  typedef struct packed {
    logic line_drive;
    logic busy;
    logic done;
  } bus_status_t;

endpackage

// ===== design/one_wire_temperature_reader.sv =====
// ----------------------------------------------------------------------------
// one_wire_temperature_reader
// One-wire bus master that reads a sensor temperature, one bus tick per
// transaction, with a registered result stage.
// ----------------------------------------------------------------------------
// Each input transaction is one bus tick and yields exactly one result
// transaction in the next cycle; a new tick is taken every cycle in which
// the result register is empty or being drained, so the only back-pressure
// comes from a stalled result side. The result reports the bus state before
// the tick is applied: line level, busy, done and the held reading split
// into whole degrees, tens, ones and tenths digits. Timing registers take
// effect at once and a zero length counts as one tick.
// ----------------------------------------------------------------------------
module one_wire_temperature_reader
  import owtr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_start_req,
  input  logic              in_line_in,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_line_drive,
  output logic              out_busy_res,
  output logic              out_done_res,
  output logic [BYTE_W-1:0] out_whole_degrees,
  output logic [TENS_W-1:0] out_tens_digit,
  output logic [NIB_W-1:0]  out_ones_digit,
  output logic [NIB_W-1:0]  out_tenths_digit,
  input  logic              cfg_we,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [LONG_W-1:0] cfg_wdata
);

  cfg_t              cfg_r;
  bus_status_t       status;
  logic [BYTE_W-1:0] temperature;
  logic [NIB_W-1:0]  tenths;
  logic              accept;
  logic [15:0]       recip_prod;
  logic [TENS_W-1:0] tens;
  logic [BYTE_W-1:0] tens_x10;
  logic [BYTE_W-1:0] ones_full;

  logic              out_valid_r;
  bus_status_t       status_r;
  logic [BYTE_W-1:0] whole_r;
  logic [TENS_W-1:0] tens_r;
  logic [NIB_W-1:0]  ones_r;
  logic [NIB_W-1:0]  tenths_r;

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.reset_low_len     <= RST_RESET_LOW;
      cfg_r.presence_wait_len <= RST_PRESENCE_WAIT;
      cfg_r.recovery_len      <= RST_RECOVERY;
      cfg_r.slot_len          <= RST_SLOT;
      cfg_r.convert_wait_len  <= RST_CONVERT_WAIT;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RESET_LOW:     cfg_r.reset_low_len     <= cfg_wdata;
        REG_PRESENCE_WAIT: cfg_r.presence_wait_len <= cfg_wdata;
        REG_RECOVERY:      cfg_r.recovery_len      <= cfg_wdata;
        REG_SLOT:          cfg_r.slot_len          <= cfg_wdata[SLOT_W-1:0];
        REG_CONVERT_WAIT:  cfg_r.convert_wait_len  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  owtr_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .tick        (accept),
    .start_req   (in_start_req),
    .line_in     (in_line_in),
    .cfg         (cfg_r),
    .status      (status),
    .temperature (temperature),
    .tenths      (tenths)
  );

  assign recip_prod = temperature * RECIP_TEN;
  assign tens       = recip_prod[RECIP_SHIFT +: TENS_W];
  assign tens_x10   = {3'd0, tens} * BYTE_W'(10);
  assign ones_full  = temperature - tens_x10;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status;
      whole_r  <= temperature;
      tens_r   <= tens;
      ones_r   <= ones_full[NIB_W-1:0];
      tenths_r <= tenths;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_line_drive    = status_r.line_drive;
  assign out_busy_res      = status_r.busy;
  assign out_done_res      = status_r.done;
  assign out_whole_degrees = whole_r;
  assign out_tens_digit    = tens_r;
  assign out_ones_digit    = ones_r;
  assign out_tenths_digit  = tenths_r;

endmodule

// ===== design/owtr_seq.sv =====
// ----------------------------------------------------------------------------
// owtr_seq
// Tick sequencer: reset pulse, command writes, conversion wait and read slots.
// ----------------------------------------------------------------------------
module owtr_seq
  import owtr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              tick,
  input  logic              start_req,
  input  logic              line_in,
  input  cfg_t              cfg,
  output bus_status_t       status,
  output logic [BYTE_W-1:0] temperature,
  output logic [NIB_W-1:0]  tenths
);

  phase_t             phase_r, phase_nxt;
  logic [LONG_W-1:0]  tick_cnt_r, tick_cnt_nxt;
  logic [BIT_W-1:0]   bit_idx_r, bit_idx_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic [BYTE_W-1:0]  shift_r, shift_nxt;
  logic [BYTE_W-1:0]  low_r, low_nxt;
  logic [BYTE_W-1:0]  temp_r, temp_nxt;
  logic [NIB_W-1:0]   tenths_r, tenths_nxt;

  logic [LONG_W-1:0]  len;
  logic [LONG_W:0]    cnt_inc;
  logic               phase_end;
  logic [BYTE_W-1:0]  shift_s;
  logic               do_enter;
  logic               do_advance;
  logic [STEP_W-1:0]  enter_step;
  logic [BYTE_W-1:0]  tenths_prod;

  function automatic logic [LONG_W-1:0] at_least_one(input logic [LONG_W-1:0] v);
    at_least_one = (v == '0) ? LONG_W'(1) : v;
  endfunction

  always_comb begin
    case (phase_r)
      PH_RLOW:   len = at_least_one(cfg.reset_low_len);
      PH_RWAIT:  len = at_least_one(cfg.presence_wait_len);
      PH_RREC:   len = at_least_one(cfg.recovery_len);
      PH_WBIT:   len = at_least_one(LONG_W'(cfg.slot_len));
      PH_CWAIT:  len = at_least_one(cfg.convert_wait_len);
      PH_RDWAIT: len = at_least_one(LONG_W'(cfg.slot_len));
      default:   len = LONG_W'(1);
    endcase
  end

  assign cnt_inc     = {1'b0, tick_cnt_r} + (LONG_W+1)'(1);
  assign phase_end   = cnt_inc[LONG_W] || (cnt_inc[LONG_W-1:0] >= len);
  assign shift_s     = (phase_r == PH_RDWAIT && tick_cnt_r == '0) ?
                       {line_in, shift_r[BYTE_W-1:1]} : shift_r;
  assign tenths_prod = {4'd0, low_r[NIB_W-1:0]} * BYTE_W'(10);

  // next state
  always_comb begin
    phase_nxt    = phase_r;
    tick_cnt_nxt = tick_cnt_r;
    bit_idx_nxt  = bit_idx_r;
    step_nxt     = step_r;
    shift_nxt    = shift_r;
    low_nxt      = low_r;
    temp_nxt     = temp_r;
    tenths_nxt   = tenths_r;
    do_enter     = 1'b0;
    do_advance   = 1'b0;
    enter_step   = step_r;

    if (tick) begin
      case (phase_r)
        PH_IDLE: begin
          if (start_req) begin
            step_nxt   = STEP_RESET_A;
            enter_step = STEP_RESET_A;
            do_enter   = 1'b1;
          end
        end
        PH_DONE: begin
          phase_nxt    = PH_IDLE;
          tick_cnt_nxt = '0;
        end
        default: begin
          shift_nxt = shift_s;
          if (!phase_end) begin
            tick_cnt_nxt = cnt_inc[LONG_W-1:0];
          end else begin
            tick_cnt_nxt = '0;
            case (phase_r)
              PH_RLOW:  phase_nxt = PH_RWAIT;
              PH_RWAIT: phase_nxt = PH_RREC;
              PH_WLOW:  phase_nxt = PH_WBIT;
              PH_WBIT: begin
                shift_nxt = {1'b0, shift_s[BYTE_W-1:1]};
                if (bit_idx_r == LAST_BIT) begin
                  phase_nxt = PH_WEND;
                end else begin
                  bit_idx_nxt = bit_idx_r + BIT_W'(1);
                  phase_nxt   = PH_WLOW;
                end
              end
              PH_RDLOW: phase_nxt = PH_RDREL;
              PH_RDREL: phase_nxt = PH_RDWAIT;
              PH_RDWAIT: begin
                if (bit_idx_r == LAST_BIT) begin
                  do_advance = 1'b1;
                end else begin
                  bit_idx_nxt = bit_idx_r + BIT_W'(1);
                  phase_nxt   = PH_RDLOW;
                end
              end
              PH_RREC, PH_WEND, PH_CWAIT: do_advance = 1'b1;
              default: phase_nxt = PH_IDLE;
            endcase
          end
        end
      endcase
    end

    if (do_advance) begin
      if (step_r == STEP_READ_LO) begin
        low_nxt = shift_s;
      end else if (step_r == STEP_READ_HI) begin
        temp_nxt   = {shift_s[NIB_W-1:0], low_r[BYTE_W-1:NIB_W]};
        tenths_nxt = tenths_prod[BYTE_W-1:NIB_W];
      end
      step_nxt   = step_r + STEP_W'(1);
      enter_step = step_r + STEP_W'(1);
      do_enter   = 1'b1;
    end

    if (do_enter) begin
      tick_cnt_nxt = '0;
      bit_idx_nxt  = '0;
      case (enter_step)
        STEP_RESET_A, STEP_RESET_B: phase_nxt = PH_RLOW;
        STEP_SKIP_A, STEP_SKIP_B: begin
          shift_nxt = CMD_SKIP_ROM;
          phase_nxt = PH_WLOW;
        end
        STEP_CONVERT: begin
          shift_nxt = CMD_CONVERT;
          phase_nxt = PH_WLOW;
        end
        STEP_READ_CMD: begin
          shift_nxt = CMD_READ_PAD;
          phase_nxt = PH_WLOW;
        end
        STEP_WAIT_A, STEP_WAIT_B: phase_nxt = PH_CWAIT;
        STEP_READ_LO, STEP_READ_HI: begin
          shift_nxt = '0;
          phase_nxt = PH_RDLOW;
        end
        STEP_FINISH: phase_nxt = PH_DONE;
        default:     phase_nxt = PH_IDLE;
      endcase
    end
  end

  // outputs
  always_comb begin
    status.busy       = 1'b1;
    status.done       = 1'b0;
    status.line_drive = 1'b1;
    case (phase_r)
      PH_IDLE: status.busy = 1'b0;
      PH_DONE: begin
        status.busy = 1'b0;
        status.done = 1'b1;
      end
      PH_RLOW, PH_WLOW, PH_RDLOW: status.line_drive = 1'b0;
      PH_WBIT: status.line_drive = shift_r[0];
      default: status.line_drive = 1'b1;
    endcase
  end

  assign temperature = temp_r;
  assign tenths      = tenths_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      tick_cnt_r <= '0;
      bit_idx_r  <= '0;
      step_r     <= '0;
      shift_r    <= '0;
      low_r      <= '0;
      temp_r     <= '0;
      tenths_r   <= '0;
    end else begin
      phase_r    <= phase_nxt;
      tick_cnt_r <= tick_cnt_nxt;
      bit_idx_r  <= bit_idx_nxt;
      step_r     <= step_nxt;
      shift_r    <= shift_nxt;
      low_r      <= low_nxt;
      temp_r     <= temp_nxt;
      tenths_r   <= tenths_nxt;
    end
  end

endmodule
